[rtl/l4pms_pkg.sv]
package l4pms_pkg;

    localparam int DEF_RULE_SLOTS      = 16;
    localparam int DEF_SNAP_LEN        = 196;
    localparam int DEF_MAX_FRAME_BYTES = 16383;

    // Wide enough for any frame length or snap length in range.
    localparam int LEN_W = 17;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam int          ETH_HDR        = 14;
    localparam int          IP_MIN         = 20;
    localparam int          TCP_HDR        = 20;
    localparam int          UDP_HDR        = 8;
    localparam int          POS_ETYPE_HI   = 12;
    localparam int          POS_ETYPE_LO   = 13;
    localparam int          POS_IHL        = 14;
    localparam int          POS_PROTO      = 23;
    localparam int          DMAC_END       = 6;
    localparam int          SMAC_END       = 12;

    typedef enum logic
    {
        CMD_RULE = 1'b0,
        CMD_BYTE = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        VERDICT_PASS     = 2'd0,
        VERDICT_REDIRECT = 2'd1,
        VERDICT_CLONE    = 2'd2
    } verdict_t;

    typedef struct packed
    {
        command_t    command;
        logic [3:0]  rule_slot;
        logic        rule_valid;
        logic        rule_is_udp;
        logic [15:0] rule_port;
        logic [31:0] rule_egress_index;
        logic        rule_redirect;
        logic [47:0] rule_dest_mac;
        logic [47:0] rule_source_mac;
        logic [7:0]  frame_byte;
        logic        frame_last;
    } in_word_t;

    typedef struct packed
    {
        verdict_t    verdict;
        logic [31:0] egress_index;
        logic [47:0] new_dest_mac;
        logic [47:0] new_source_mac;
        logic        matched_is_udp;
        logic [15:0] matched_port;
        logic [7:0]  snapped_length;
        logic [13:0] truncated_bytes;
    } out_word_t;

    // Header fields as they stand after the current byte is captured.
    typedef struct packed
    {
        logic [LEN_W-1:0] len;
        logic [15:0]      ether_type;
        logic [3:0]       ihl;
        logic [7:0]       proto;
        logic [15:0]      port;
        logic [47:0]      dmac;
        logic [47:0]      smac;
    } hdr_t;

    typedef struct packed
    {
        logic        hit;
        logic        redirect;
        logic [31:0] egress;
        logic [47:0] dmac;
        logic [47:0] smac;
    } match_t;

endpackage

[rtl/l4pms_parser.sv]
module l4pms_parser #(
    parameter int MAX_FRAME_BYTES = l4pms_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        frame_byte,
    input  logic              frame_last,
    output l4pms_pkg::hdr_t   hdr
);

    localparam int OW = $clog2(MAX_FRAME_BYTES + 1);

    logic [OW-1:0] offset_reg, offset_next;
    logic [15:0]   etype_reg, etype_next;
    logic [3:0]    ihl_reg, ihl_next;
    logic [7:0]    proto_reg, proto_next;
    logic [15:0]   port_reg, port_next;
    logic [47:0]   dmac_reg, dmac_next;
    logic [47:0]   smac_reg, smac_next;
    logic          capt;
    logic [OW-1:0] port_at;

    assign capt    = offset_reg < OW'(MAX_FRAME_BYTES);
    assign port_at = OW'(l4pms_pkg::ETH_HDR + 2) + OW'({ihl_reg, 2'b00});

    always_comb
    begin
        offset_next = offset_reg;
        etype_next  = etype_reg;
        ihl_next    = ihl_reg;
        proto_next  = proto_reg;
        port_next   = port_reg;
        dmac_next   = dmac_reg;
        smac_next   = smac_reg;
        if (capt)
        begin
            offset_next = offset_reg + OW'(1);
            if (offset_reg < OW'(l4pms_pkg::DMAC_END))
                dmac_next = {dmac_reg[39:0], frame_byte};
            else if (offset_reg < OW'(l4pms_pkg::SMAC_END))
                smac_next = {smac_reg[39:0], frame_byte};
            else if (offset_reg == OW'(l4pms_pkg::POS_ETYPE_HI))
                etype_next = {frame_byte, etype_reg[7:0]};
            else if (offset_reg == OW'(l4pms_pkg::POS_ETYPE_LO))
                etype_next = {etype_reg[15:8], frame_byte};
            else if (offset_reg == OW'(l4pms_pkg::POS_IHL))
                ihl_next = frame_byte[3:0];
            if (offset_reg == OW'(l4pms_pkg::POS_PROTO))
                proto_next = frame_byte;
            if (offset_reg > OW'(l4pms_pkg::POS_IHL))
            begin
                if (offset_reg == port_at)
                    port_next = {frame_byte, port_reg[7:0]};
                if (offset_reg == port_at + OW'(1))
                    port_next = {port_reg[15:8], frame_byte};
            end
        end
    end

    assign hdr.len        = l4pms_pkg::LEN_W'(offset_next);
    assign hdr.ether_type = etype_next;
    assign hdr.ihl        = ihl_next;
    assign hdr.proto      = proto_next;
    assign hdr.port       = port_next;
    assign hdr.dmac       = dmac_next;
    assign hdr.smac       = smac_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            etype_reg  <= '0;
            ihl_reg    <= '0;
            proto_reg  <= '0;
            port_reg   <= '0;
            dmac_reg   <= '0;
            smac_reg   <= '0;
        end
        else if (step)
        begin
            if (frame_last)
            begin
                offset_reg <= '0;
                etype_reg  <= '0;
                ihl_reg    <= '0;
                proto_reg  <= '0;
                port_reg   <= '0;
                dmac_reg   <= '0;
                smac_reg   <= '0;
            end
            else
            begin
                offset_reg <= offset_next;
                etype_reg  <= etype_next;
                ihl_reg    <= ihl_next;
                proto_reg  <= proto_next;
                port_reg   <= port_next;
                dmac_reg   <= dmac_next;
                smac_reg   <= smac_next;
            end
        end
    end

endmodule

[rtl/l4pms_rule_table.sv]
module l4pms_rule_table #(
    parameter int RULE_SLOTS = l4pms_pkg::DEF_RULE_SLOTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  l4pms_pkg::in_word_t  wr_word,
    input  logic                 key_udp,
    input  logic [15:0]          key_port,
    output l4pms_pkg::match_t    match
);

    localparam int SIW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int AW  = (SIW > 4) ? SIW : 4;
    localparam int CW  = AW + 1;

    logic [RULE_SLOTS-1:0] key_valid_reg;
    logic [RULE_SLOTS-1:0] key_udp_reg;
    logic [15:0]           key_port_reg [RULE_SLOTS];

    logic [31:0] egress_mem [RULE_SLOTS];
    logic        mode_mem   [RULE_SLOTS];
    logic [47:0] dmac_mem   [RULE_SLOTS];
    logic [47:0] smac_mem   [RULE_SLOTS];

    logic [AW-1:0]         slot_ext;
    logic [SIW-1:0]        wr_idx;
    logic                  wr_ok;
    logic [RULE_SLOTS-1:0] hits;
    logic [SIW-1:0]        hit_idx;

    assign slot_ext = AW'(wr_word.rule_slot);
    assign wr_idx   = slot_ext[SIW-1:0];
    assign wr_ok    = wr_en && (CW'(slot_ext) < CW'(RULE_SLOTS));

    // Parallel compare, lowest slot wins.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < RULE_SLOTS; i++)
            hits[i] = key_valid_reg[i] && (key_udp_reg[i] == key_udp)
                      && (key_port_reg[i] == key_port);
        for (int i = RULE_SLOTS - 1; i >= 0; i--)
            if (hits[i])
                hit_idx = SIW'(i);
    end

    assign match.hit      = |hits;
    assign match.redirect = mode_mem[hit_idx];
    assign match.egress   = egress_mem[hit_idx];
    assign match.dmac     = dmac_mem[hit_idx];
    assign match.smac     = smac_mem[hit_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= '0;
            key_udp_reg   <= '0;
            for (int i = 0; i < RULE_SLOTS; i++)
                key_port_reg[i] <= '0;
        end
        else if (wr_ok)
        begin
            key_valid_reg[wr_idx] <= wr_word.rule_valid;
            key_udp_reg[wr_idx]   <= wr_word.rule_is_udp;
            key_port_reg[wr_idx]  <= wr_word.rule_port;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            egress_mem[wr_idx] <= wr_word.rule_egress_index;
            mode_mem[wr_idx]   <= wr_word.rule_redirect;
            dmac_mem[wr_idx]   <= wr_word.rule_dest_mac;
            smac_mem[wr_idx]   <= wr_word.rule_source_mac;
        end
    end

endmodule

[rtl/l4_port_match_steering.sv]
// Layer-4 port steering classifier. Words arrive one per cycle on the in
// channel while in_ready is high: a rule word (command = rule) loads one
// slot of the rule table, a frame word (command = byte) carries one frame
// byte. Header fields (MACs, ethertype, IHL, protocol and the TCP/UDP
// destination port at offset 14+4*IHL+2) are captured on the fly. On the
// frame's last byte the length checks, the parallel compare over all rule
// slots (lowest slot wins) and the result assembly run combinationally,
// and exactly one out word per frame is produced; rule words and non-last
// bytes produce nothing. Throughput is one word per clock unless stalled;
// a word is held in the input register and its result in the result
// register, which drives out. The input register doubles as a skid stage:
// while a result waits on out_ready, rule words and non-last bytes keep
// flowing, and the input stalls only once a second last byte sits in the
// input register. A combinational slot compare over RULE_SLOTS entries
// plus the capture mux sets the critical path. Rule slot actions have no
// reset; only slot valid bits and keys are cleared at reset, so no clearing
// pass is needed. cfg_wr_data sets the ingress interface index used when a
// rule's egress index is zero; write it only while the block is idle.
module l4_port_match_steering #(
    parameter int RULE_SLOTS      = l4pms_pkg::DEF_RULE_SLOTS,
    parameter int SNAP_LEN        = l4pms_pkg::DEF_SNAP_LEN,
    parameter int MAX_FRAME_BYTES = l4pms_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  l4pms_pkg::in_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output l4pms_pkg::out_word_t out_word,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data
);

    localparam int LW = l4pms_pkg::LEN_W;

    // Input register (skid stage).
    logic                 in_valid_reg, in_valid_next;
    l4pms_pkg::in_word_t  in_word_reg;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    l4pms_pkg::out_word_t out_word_reg;
    l4pms_pkg::out_word_t result;

    logic [31:0]          ingress_reg;

    logic                 is_byte;
    logic                 produces;
    logic                 out_free;
    logic                 in_adv;
    logic                 in_take;

    l4pms_pkg::hdr_t      hdr;
    l4pms_pkg::match_t    match;

    logic                 is_udp;
    logic                 is_tcp;
    logic [LW-1:0]        ihl_end;
    logic [LW-1:0]        l4_end;
    logic                 len_ok;
    logic [LW-1:0]        snapped;
    logic [LW-1:0]        trunc;

    assign is_byte  = in_word_reg.command == l4pms_pkg::CMD_BYTE;
    assign produces = is_byte && in_word_reg.frame_last;
    assign out_free = !out_valid_reg || out_ready;
    assign in_adv   = in_valid_reg && (!produces || out_free);
    assign in_ready = !in_valid_reg || in_adv;
    assign in_take  = in_valid && in_ready;

    assign in_valid_next  = in_take || (in_valid_reg && !in_adv);
    assign out_valid_next = (in_adv && produces) || (out_valid_reg && !out_ready);

    l4pms_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_adv && is_byte),
        .frame_byte (in_word_reg.frame_byte),
        .frame_last (in_word_reg.frame_last),
        .hdr        (hdr)
    );

    assign is_udp = hdr.proto == l4pms_pkg::PROTO_UDP;
    assign is_tcp = hdr.proto == l4pms_pkg::PROTO_TCP;

    l4pms_rule_table #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_rule_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_adv && !is_byte),
        .wr_word  (in_word_reg),
        .key_udp  (is_udp),
        .key_port (hdr.port),
        .match    (match)
    );

    // Length checks against Ethernet, IP and L4 header ends.
    assign ihl_end = LW'(l4pms_pkg::ETH_HDR) + LW'({hdr.ihl, 2'b00});
    assign l4_end  = ihl_end + (is_udp ? LW'(l4pms_pkg::UDP_HDR) : LW'(l4pms_pkg::TCP_HDR));
    assign len_ok  = (hdr.ether_type == l4pms_pkg::ETHERTYPE_IPV4)
                     && (hdr.len >= LW'(l4pms_pkg::ETH_HDR + l4pms_pkg::IP_MIN))
                     && (is_udp || is_tcp)
                     && (hdr.len >= ihl_end) && (hdr.len >= l4_end);

    assign snapped = (hdr.len > LW'(SNAP_LEN)) ? LW'(SNAP_LEN) : hdr.len;
    assign trunc   = hdr.len - snapped;

    always_comb
    begin
        result = '0;
        if (len_ok && match.hit)
        begin
            result.verdict         = match.redirect ? l4pms_pkg::VERDICT_REDIRECT
                                                    : l4pms_pkg::VERDICT_CLONE;
            result.egress_index    = (match.egress != '0) ? match.egress : ingress_reg;
            result.new_dest_mac    = (match.dmac != '0) ? match.dmac : hdr.dmac;
            result.new_source_mac  = (match.smac != '0) ? match.smac : hdr.smac;
            result.matched_is_udp  = is_udp;
            result.matched_port    = hdr.port;
            result.snapped_length  = snapped[7:0];
            result.truncated_bytes = trunc[13:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ingress_reg   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                ingress_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_word_reg <= in_word;
        if (in_adv && produces)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A held input word means the stage is full.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg)
        else $error("in_ready low with empty input stage");

    // A last byte that moves on always yields a result next cycle.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_adv && produces) |=> out_valid)
        else $error("last byte produced no result");

    // Non-last words never create a result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || out_ready) && !(in_adv && produces) |=> !out_valid)
        else $error("result without a last byte");

    // A pass verdict carries zero egress, port, snapped and truncated fields.
    a_pass_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.verdict == l4pms_pkg::VERDICT_PASS)
            |-> (out_word.egress_index == '0 && out_word.matched_port == '0
                 && out_word.snapped_length == '0 && out_word.truncated_bytes == '0))
        else $error("pass verdict with nonzero fields");

    // Truncation only happens once the snap length is filled.
    a_trunc_snap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.truncated_bytes != '0)
            |-> out_word.snapped_length == 8'(SNAP_LEN))
        else $error("truncated bytes below snap length");

endmodule
